// ===== rtl/core/alte_pkg.sv =====
// Package for the array list table engine: field widths, command, status
// and state codes, the item structs and the controller/datapath link types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package alte_pkg;

   // Fixed field widths of the item formats
   localparam int IDX_W     = 10;
   localparam int VAL_W     = 32;
   localparam int CNT_OUT_W = 11;

   // Default list capacity
   localparam int DEPTH_DEF = 1024;

   typedef enum logic [1:0] {
      CMD_APPEND  = 2'd0,
      CMD_REMOVE  = 2'd1,
      CMD_REPLACE = 2'd2,
      CMD_FIND    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_BADIDX   = 2'd2,
      ST_NOTFOUND = 2'd3
   } stat_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_REPL_WR,
      S_SHIFT,
      S_FIND,
      S_RESULT
   } state_type;

   typedef struct packed {
      cmd_type                  cmd;
      logic [IDX_W-1:0]         index;
      logic signed [VAL_W-1:0]  value;
   } req_type;

   typedef struct packed {
      stat_type                 status;
      logic [IDX_W-1:0]         found_index;
      logic signed [VAL_W-1:0]  old_value;
      logic [CNT_OUT_W-1:0]     count;
   } rsp_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic     latch;          // capture the request item
      logic     append_wr;      // write value at the end, bump count
      logic     repl_wr;        // write value at index, keep old word
      logic     rd_en;          // issue a memory read
      logic     rd_idx;         // read address from the request index
      logic     rd_shift;       // read data goes back one place down
      logic     ptr_load_next;  // ptr <= index + 1
      logic     ptr_load_zero;  // ptr <= 0
      logic     ptr_inc;        // ptr <= ptr + 1
      logic     count_dec;      // drop one entry
      logic     stat_ld;        // load status code
      stat_type stat_code;
      logic     found_ld;       // found index <= last read address
      logic     out_ld;         // move result into the output register
   } ctl_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      cmd_type cmd;
      logic    full;
      logic    bad_idx;
      logic    ptr_end;
      logic    rd_vld;
      logic    match;
      logic    out_free;
   } dp_stat_type;

endpackage

`default_nettype wire

// ===== rtl/core/alte_ctrl.sv =====
// Controller for the array list table engine: sequences each command
// through decode, memory walk and result hand-off. Uses alte_pkg.
`timescale 1ns / 1ps
`default_nettype none

module alte_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire alte_pkg::dp_stat_type st,
   output alte_pkg::ctl_cmd_type     ctl
);

   alte_pkg::state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= alte_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         alte_pkg::S_IDLE: begin
            if (req_valid) state_in = alte_pkg::S_DECODE;
         end
         alte_pkg::S_DECODE: begin
            case (st.cmd)
               alte_pkg::CMD_APPEND:  state_in = alte_pkg::S_RESULT;
               alte_pkg::CMD_REMOVE:
                  state_in = st.bad_idx ? alte_pkg::S_RESULT : alte_pkg::S_SHIFT;
               alte_pkg::CMD_REPLACE:
                  state_in = st.bad_idx ? alte_pkg::S_RESULT : alte_pkg::S_REPL_WR;
               alte_pkg::CMD_FIND:    state_in = alte_pkg::S_FIND;
               default:               state_in = alte_pkg::S_RESULT;
            endcase
         end
         alte_pkg::S_REPL_WR: state_in = alte_pkg::S_RESULT;
         alte_pkg::S_SHIFT: begin
            // done once all reads are issued and the last write-back landed
            if (st.ptr_end && !st.rd_vld) state_in = alte_pkg::S_RESULT;
         end
         alte_pkg::S_FIND: begin
            if (st.rd_vld && st.match) begin
               state_in = alte_pkg::S_RESULT;
            end else if (st.ptr_end && !st.rd_vld) begin
               state_in = alte_pkg::S_RESULT;
            end
         end
         alte_pkg::S_RESULT: begin
            if (st.out_free) state_in = alte_pkg::S_IDLE;
         end
         default: state_in = alte_pkg::S_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      ctl       = '0;
      req_ready = 1'b0;
      ctl.stat_code = alte_pkg::ST_OK;
      case (state_ff)
         alte_pkg::S_IDLE: begin
            req_ready = 1'b1;
            ctl.latch = req_valid;
         end
         alte_pkg::S_DECODE: begin
            ctl.stat_ld = 1'b1;
            case (st.cmd)
               alte_pkg::CMD_APPEND: begin
                  if (st.full) begin
                     ctl.stat_code = alte_pkg::ST_FULL;
                  end else begin
                     ctl.append_wr = 1'b1;
                  end
               end
               alte_pkg::CMD_REMOVE: begin
                  if (st.bad_idx) begin
                     ctl.stat_code = alte_pkg::ST_BADIDX;
                  end else begin
                     ctl.ptr_load_next = 1'b1;
                  end
               end
               alte_pkg::CMD_REPLACE: begin
                  if (st.bad_idx) begin
                     ctl.stat_code = alte_pkg::ST_BADIDX;
                  end else begin
                     ctl.rd_en  = 1'b1;
                     ctl.rd_idx = 1'b1;
                  end
               end
               alte_pkg::CMD_FIND: begin
                  ctl.stat_code     = alte_pkg::ST_NOTFOUND;
                  ctl.ptr_load_zero = 1'b1;
               end
               default: ctl.stat_code = alte_pkg::ST_OK;
            endcase
         end
         alte_pkg::S_REPL_WR: begin
            ctl.repl_wr = 1'b1;
         end
         alte_pkg::S_SHIFT: begin
            if (!st.ptr_end) begin
               ctl.rd_en    = 1'b1;
               ctl.rd_shift = 1'b1;
               ctl.ptr_inc  = 1'b1;
            end else if (!st.rd_vld) begin
               ctl.count_dec = 1'b1;
            end
         end
         alte_pkg::S_FIND: begin
            if (st.rd_vld && st.match) begin
               ctl.found_ld  = 1'b1;
               ctl.stat_ld   = 1'b1;
               ctl.stat_code = alte_pkg::ST_OK;
            end else if (!st.ptr_end) begin
               ctl.rd_en   = 1'b1;
               ctl.ptr_inc = 1'b1;
            end
         end
         alte_pkg::S_RESULT: begin
            ctl.out_ld = st.out_free;
         end
         default: ctl = '0;
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/core/alte_dp.sv =====
// Datapath for the array list table engine: entry memory, fill count,
// walk pointer, request capture and the result output register. Uses alte_pkg.
`timescale 1ns / 1ps
`default_nettype none

module alte_dp #(
   parameter int DEPTH = alte_pkg::DEPTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire alte_pkg::req_type     req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output alte_pkg::rsp_type          rsp_data,
   input  wire alte_pkg::ctl_cmd_type ctl,
   output alte_pkg::dp_stat_type      st
);

   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int CMP_W  = (CNT_W > alte_pkg::IDX_W) ? CNT_W : alte_pkg::IDX_W;

   // Entry memory
   logic signed [alte_pkg::VAL_W-1:0] mem_ff [DEPTH];

   alte_pkg::req_type                 req_ff;
   logic [CNT_W-1:0]                  count_ff, count_in;
   logic [CNT_W-1:0]                  ptr_ff, ptr_in;
   logic [ADDR_W-1:0]                 rd_addr_ff, rd_addr_in;
   logic                              rd_vld_ff;
   logic                              wb_ff;
   logic signed [alte_pkg::VAL_W-1:0] rdata_ff;
   alte_pkg::stat_type                stat_ff;
   logic [ADDR_W-1:0]                 found_ff;
   logic signed [alte_pkg::VAL_W-1:0] old_ff;
   logic                              rsp_valid_ff;
   alte_pkg::rsp_type                 rsp_ff;

   logic [CMP_W-1:0]                  idx_ext;
   logic [ADDR_W-1:0]                 idx_addr;
   logic                              we;
   logic [ADDR_W-1:0]                 wa;
   logic signed [alte_pkg::VAL_W-1:0] wd;

   assign idx_ext  = CMP_W'(req_ff.index);
   assign idx_addr = idx_ext[ADDR_W-1:0];

   // Status to the controller
   always_comb begin
      st          = '0;
      st.cmd      = req_ff.cmd;
      st.full     = (count_ff >= CNT_W'(DEPTH));
      st.bad_idx  = (idx_ext >= CMP_W'(count_ff)) || (idx_ext >= CMP_W'(DEPTH));
      st.ptr_end  = (ptr_ff >= count_ff);
      st.rd_vld   = rd_vld_ff;
      st.match    = (rdata_ff == req_ff.value);
      st.out_free = !rsp_valid_ff || rsp_ready;
   end

   // Request capture
   always_ff @(posedge clock) begin
      if (ctl.latch) req_ff <= req_data;
   end

   // Fill count
   always_comb begin
      count_in = count_ff;
      if (ctl.append_wr) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctl.count_dec) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Walk pointer
   always_comb begin
      ptr_in = ptr_ff;
      if (ctl.ptr_load_next) begin
         ptr_in = idx_ext[CNT_W-1:0] + CNT_W'(1);
      end else if (ctl.ptr_load_zero) begin
         ptr_in = '0;
      end else if (ctl.ptr_inc) begin
         ptr_in = ptr_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
   end

   // Memory write port: append, replace or shift write-back
   always_comb begin
      we = 1'b0;
      wa = count_ff[ADDR_W-1:0];
      wd = req_ff.value;
      if (ctl.append_wr) begin
         we = 1'b1;
      end else if (ctl.repl_wr) begin
         we = 1'b1;
         wa = idx_addr;
      end else if (wb_ff && rd_vld_ff) begin
         we = 1'b1;
         wa = rd_addr_ff - ADDR_W'(1);
         wd = rdata_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (we) mem_ff[wa] <= wd;
   end

   // Memory read port, registered data
   assign rd_addr_in = ctl.rd_idx ? idx_addr : ptr_ff[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rdata_ff   <= mem_ff[rd_addr_in];
         rd_addr_ff <= rd_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
         wb_ff     <= 1'b0;
      end else begin
         rd_vld_ff <= ctl.rd_en;
         wb_ff     <= ctl.rd_en && ctl.rd_shift;
      end
   end

   // Result fields
   always_ff @(posedge clock) begin
      if (ctl.latch) begin
         found_ff <= '0;
         old_ff   <= '0;
      end else begin
         if (ctl.found_ld) found_ff <= rd_addr_ff;
         if (ctl.repl_wr)  old_ff   <= rdata_ff;
      end
      if (ctl.stat_ld) stat_ff <= ctl.stat_code;
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.out_ld) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.out_ld) begin
         rsp_ff.status      <= stat_ff;
         rsp_ff.found_index <= alte_pkg::IDX_W'(found_ff);
         rsp_ff.old_value   <= old_ff;
         rsp_ff.count       <= alte_pkg::CNT_OUT_W'(count_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ===== rtl/core/array_list_table_engine.sv =====
// Array list table engine, top level: controller plus datapath.
// Remove and find walk the entries over the one-read, one-write entry memory. One
// item at a time: the next can be taken the cycle after its result enters the
// output register.
// Reset (synchronous) clears the fill count and control; entry memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module array_list_table_engine #(
   parameter int DEPTH = alte_pkg::DEPTH_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire alte_pkg::req_type  req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output alte_pkg::rsp_type       rsp_data
);

   alte_pkg::ctl_cmd_type ctl;
   alte_pkg::dp_stat_type st;

   alte_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .st        (st),
      .ctl       (ctl)
   );

   alte_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .ctl       (ctl),
      .st        (st)
   );

endmodule

`default_nettype wire
